@@ rtl/core/mavg_pkg.sv @@
// Shared types and constants of the moving average filter.
package mavg_pkg;

    // Width and reset value of the window length register
    localparam int                  CFG_LEN_BITS  = 7;
    localparam logic [CFG_LEN_BITS-1:0] CFG_LEN_RESET = 7'd7;

    // Status of the iterative divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/core/mavg_if.sv @@
// Valid/ready channel interfaces for samples, averages and the window length register.
interface mavg_sample_if
    import mavg_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_average_if
    import mavg_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

interface mavg_cfg_if
    import mavg_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_LEN_BITS-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

@@ rtl/core/moving_average_filter_top.sv @@
// Top level of the moving average filter: sample ring, running sum and sequencer.
//
//  channel   role   payload                    beat taken when
//  samples   sink   sample   [SAMPLE_BITS]     valid && ready
//  averages  source average  [SAMPLE_BITS]     valid && ready
//  cfg       sink   window_length [7]          valid && ready
//
// Once the window is full, a sample passes through these steps before the next beat can
// be taken: taking it, updating the ring and sum, the restoring divider working through
// the SAMPLE_BITS+7 (31 at defaults) bits of the sum, seeing the divider finish and
// loading the output register, which makes its average valid.
// A sample that only fills the window returns to idle after the update. Reset clears
// the sum, fill count and write position; the ring contents are unknown until written.
// A stalled output holds the sequencer only after the next average is ready.
module moving_average_filter_top
    import mavg_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic           clk,
    input  logic           rst_n,
    mavg_sample_if.sink    samples,
    mavg_average_if.source averages,
    mavg_cfg_if.sink       cfg
);

    localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = SAMPLE_BITS + CFG_LEN_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t                  state_reg;
    logic [CFG_LEN_BITS-1:0] len_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CFG_LEN_BITS-1:0] fill_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    full_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  old_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_data_reg;

    logic [SAMPLE_BITS-1:0]  store_mem [WINDOW_MAX];

    logic [CFG_LEN_BITS-1:0] eff_len;
    logic [POS_W-1:0]        pos_next;
    logic [SUM_W-1:0]        sum_next;
    logic                    in_beat;
    logic                    cfg_beat;
    logic                    out_beat;
    logic                    produce;
    logic                    div_start;
    logic [SUM_W-1:0]        div_quotient;
    div_status_t             div_stat;

    // Clamp the register value to a usable window length
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = CFG_LEN_BITS'(1);
        end
        else if (32'(len_reg) > WINDOW_MAX)
        begin
            eff_len = CFG_LEN_BITS'(WINDOW_MAX);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    // Wrap the write position at the window length
    always_comb
    begin
        if ((32'(pos_reg) + 32'd1) >= 32'(eff_len))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = POS_W'(32'(pos_reg) + 32'd1);
        end
    end

    // Drop the oldest sample once full, add the new one
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample_reg);
        if (full_reg)
        begin
            sum_next = sum_next - SUM_W'(old_reg);
        end
    end

    assign cfg.ready     = (state_reg == ST_IDLE);
    assign samples.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg_beat      = cfg.valid && cfg.ready;
    assign in_beat       = samples.valid && samples.ready;
    assign out_beat      = out_valid_reg && averages.ready;
    assign produce       = (fill_reg >= eff_len);
    assign div_start     = (state_reg == ST_UPDATE) && produce;

    // Ring store: read the oldest sample and write the new one in the same beat
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            old_reg            <= store_mem[pos_reg];
            store_mem[pos_reg] <= samples.sample;
        end
    end

    mavg_divider #(
        .SUM_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (eff_len),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // Sequencer, window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= CFG_LEN_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            sample_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Drop a taken average unless the deliver step reloads it
            if (out_beat && (state_reg != ST_DELIVER))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_beat)
                    begin
                        len_reg  <= cfg.window_length;
                        sum_reg  <= '0;
                        fill_reg <= '0;
                        pos_reg  <= '0;
                    end
                    else if (in_beat)
                    begin
                        sample_reg <= samples.sample;
                        full_reg   <= (fill_reg >= eff_len);
                        if (fill_reg < eff_len)
                        begin
                            fill_reg <= fill_reg + CFG_LEN_BITS'(1);
                        end
                        pos_reg   <= pos_next;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= produce ? ST_DIVIDE : ST_IDLE;
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (!out_valid_reg || averages.ready)
                    begin
                        out_data_reg  <= div_quotient[SAMPLE_BITS-1:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign averages.valid   = out_valid_reg;
    assign averages.average = out_data_reg;

`ifndef NO_ASSERTIONS
    // Fill count never passes the window length, write position stays inside it
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= eff_len) && (32'(pos_reg) < 32'(eff_len)))
        else $error("window bookkeeping out of range");

    // Divider is only started when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // A new average appears only from the deliver step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DELIVER))
        else $error("average raised outside deliver step");

    // A register write restarts the window
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_beat |=> (sum_reg == '0) && (fill_reg == '0) && (pos_reg == '0))
        else $error("window not restarted after register write");

    // The divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("divider result outside divide step");
`endif

endmodule

@@ rtl/core/mavg_divider.sv @@
// Restoring divider, one quotient bit per cycle, for window sum over window length.
module mavg_divider
    import mavg_pkg::*;
#(
    parameter int SUM_W = 31
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SUM_W-1:0]        dividend,
    input  logic [CFG_LEN_BITS-1:0] divisor,
    output logic [SUM_W-1:0]        quotient,
    output div_status_t             status
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]        quo_reg;
    logic [CFG_LEN_BITS-1:0] rem_reg;
    logic [CFG_LEN_BITS-1:0] div_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;

    logic [CFG_LEN_BITS:0]   trial;
    logic [CFG_LEN_BITS:0]   diff;
    logic                    fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // Flag the cycle after the last quotient bit
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                quo_reg <= dividend;
                rem_reg <= '0;
                div_reg <= divisor;
                cnt_reg <= CNT_W'(SUM_W);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= fits ? diff[CFG_LEN_BITS-1:0] : trial[CFG_LEN_BITS-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

@@ tb/moving_average_filter_top_test.sv @@
// Self-checking testbench for the moving average filter top level.
module moving_average_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 24;

    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [CFG_LEN_BITS-1:0] length_t;

    // Tracks the window and sum, and holds the averages still to arrive
    class window_average_board;
        sample_t     window_store [WINDOW_MAX];
        logic [29:0] running_sum;
        int          fill_count;
        int          write_position;
        length_t     window_length;
        sample_t     expected_averages [$];
        int          mismatches;

        function new();
            window_length = CFG_LEN_RESET;
            mismatches    = 0;
            restart();
        endfunction

        function void restart();
            running_sum    = '0;
            fill_count     = 0;
            write_position = 0;
        endfunction

        // Zero acts as one, anything above capacity acts as capacity
        function int span();
            if (window_length == 0)
                return 1;
            if (window_length > WINDOW_MAX)
                return WINDOW_MAX;
            return int'(window_length);
        endfunction

        // Any register write restarts the window
        function void set_length(length_t len);
            window_length = len;
            restart();
        endfunction

        function void note_sample(sample_t value);
            int          len;
            int          slot;
            logic [29:0] quotient;
            len  = span();
            slot = write_position;
            if (slot >= len)
                slot = 0;
            // Drop the oldest sample once full, else grow the fill
            if (fill_count >= len)
                running_sum = running_sum - window_store[slot];
            else
                fill_count++;
            running_sum        = running_sum + value;
            window_store[slot] = value;
            slot++;
            if (slot >= len)
                slot = 0;
            write_position = slot;
            if (fill_count >= len)
            begin
                quotient = running_sum / 30'(len);
                expected_averages.push_back(quotient[SAMPLE_BITS-1:0]);
            end
        endfunction

        function void check_average(sample_t actual);
            sample_t expected;
            if (expected_averages.size() == 0)
            begin
                mismatches++;
                $display("%0t: average expected none actual %0d", $time, actual);
                return;
            end
            expected = expected_averages.pop_front();
            if (actual !== expected)
            begin
                mismatches++;
                $display("%0t: average expected %0d actual %0d", $time, expected, actual);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_off;

    window_average_board board = new();

    mavg_sample_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    mavg_average_if #(.SAMPLE_BITS(SAMPLE_BITS)) average_ch ();
    mavg_cfg_if                                  cfg_ch ();

    moving_average_filter_top #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .averages (average_ch),
        .cfg      (cfg_ch)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lower valid and keep the payload moving while idle
    task automatic pause_samples(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            sample_ch.valid  = 1'b0;
            sample_ch.sample = sample_t'($urandom);
        end
    endtask

    // Offer one sample beat and hold it until taken
    task automatic push_sample(sample_t value);
        if ($urandom_range(99) < send_idle_pct)
            pause_samples($urandom_range(1, 8));
        @(negedge clk);
        sample_ch.valid  = 1'b1;
        sample_ch.sample = value;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        board.note_sample(value);
    endtask

    // Wait until every average has come and the sequencer has gone quiet
    task automatic settle();
        pause_samples(1);
        while (board.expected_averages.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_length(length_t len);
        settle();
        @(negedge clk);
        cfg_ch.valid         = 1'b1;
        cfg_ch.window_length = len;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        board.set_length(len);
        @(negedge clk);
        cfg_ch.valid         = 1'b0;
        cfg_ch.window_length = length_t'($urandom);
    endtask

    // Bias toward the extremes now and then
    function automatic sample_t random_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(255));
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic int span_of(length_t len);
        if (len == 0)
            return 1;
        if (len > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(len);
    endfunction

    // Take average beats, stalling at random or during a hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            average_ch.ready = !hold_off && ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (average_ch.valid && average_ch.ready)
                board.check_average(average_ch.average);
        end
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("moving_average_filter_top_test NOT OK");
        $finish;
    end

    initial
    begin
        length_t fixed_lengths [5] = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd65};
        length_t len;
        int      sent;
        int      segment;
        int      count;
        bit      hold_done;

        rst_n                = 1'b0;
        sample_ch.valid      = 1'b0;
        sample_ch.sample     = '0;
        average_ch.ready     = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.window_length = '0;
        hold_off             = 1'b0;
        send_idle_pct        = 20;
        recv_idle_pct        = 66;
        sent                 = 0;
        segment              = 0;
        hold_done            = 1'b0;

        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset window of seven: full-scale fill, then a drop to zero
        repeat (7) push_sample('1);
        push_sample('0);
        push_sample(24'h800000);

        // Window of one passes samples straight through
        write_length(7'd1);
        push_sample('0);
        push_sample('1);
        push_sample(24'hAAAAAA);
        push_sample(24'h555555);

        // Zero length behaves as one
        write_length(7'd0);
        push_sample(24'h123456);
        push_sample('0);

        // Rewrite the same length mid-window to restart it
        write_length(7'd2);
        push_sample(24'h000001);
        write_length(7'd2);
        push_sample(24'h000003);
        push_sample(24'h000004);
        push_sample(24'h000005);

        // Random segments, each at a new length and cut at a random point
        while (sent < 1400)
        begin
            if (sent < 467)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 66;
            end
            else if (sent < 934)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (segment < 5)
                len = fixed_lengths[segment];
            else if ($urandom_range(9) == 0)
                len = length_t'($urandom_range(33, 127));
            else
                len = length_t'($urandom_range(1, 12));
            segment++;
            write_length(len);
            count = span_of(len) + $urandom_range(3, 40);

            // Stall the output for a long stretch while samples keep coming
            if (send_idle_pct == 0 && !hold_done)
            begin
                hold_done = 1'b1;
                fork
                    begin
                        @(posedge clk);
                        hold_off = 1'b1;
                        repeat (800) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end

            repeat (count)
            begin
                push_sample(random_sample());
                sent++;
            end
        end

        // Drain and report
        settle();
        if (board.mismatches == 0 && board.expected_averages.size() == 0)
            $display("moving_average_filter_top_test OK");
        else
            $display("moving_average_filter_top_test NOT OK");
        $finish;
    end

endmodule
